// ----- design/wht_pkg.sv -----
`default_nettype none
package wht_pkg;

    typedef enum logic [2:0] {
        CMD_RESET   = 3'd0,
        CMD_PUSH    = 3'd1,
        CMD_DISABLE = 3'd2,
        CMD_HIT     = 3'd3,
        CMD_FIND    = 3'd4
    } t_cmd;

    localparam logic [0:0] CFG_HEADER_MASK   = 1'd0;
    localparam logic [0:0] CFG_DISABLED_MASK = 1'd1;
    localparam logic [7:0] HEADER_MASK_RESET   = 8'd1;
    localparam logic [7:0] DISABLED_MASK_RESET = 8'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [31:0]        widget_id;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [31:0] entry_value;
        logic [7:0]         entry_flags;
        logic [4:0]         reject_reason;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic [31:0]        found_id;
        logic [5:0]         found_index;
        logic signed [31:0] found_value;
        logic [7:0]         found_flags;
        logic [4:0]         found_reason;
        logic [6:0]         entry_count;
        logic [15:0]        drop_count;
    } t_out;

    // one stored entry
    typedef struct packed {
        logic [31:0]        id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [31:0]        value;
        logic [7:0]         flags;
        logic [4:0]         reason;
    } t_entry;

    // query travelling down the chain
    typedef struct packed {
        logic               hit;      // 1 hit, 0 find
        logic [31:0]        id;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [7:0]         skip;
    } t_query;

endpackage
`default_nettype wire

// ----- design/wht_cell.sv -----
`default_nettype none
// one table slot: holds an entry and tests the query passed in from its neighbor
module wht_cell (
    input  wire logic           i_clk,
    input  wire logic           i_load,
    input  wire wht_pkg::t_entry i_load_entry,
    input  wire logic           i_dis,
    input  wire logic [7:0]     i_dis_mask,
    input  wire logic [4:0]     i_dis_reason,
    input  wire logic           i_valid,
    input  wire wht_pkg::t_query i_query,
    output      logic           o_valid,
    output      wht_pkg::t_query o_query,
    output      logic           o_match,
    output      wht_pkg::t_entry o_entry
);
    wht_pkg::t_entry r_entry;
    wht_pkg::t_query r_query;
    logic            r_valid;
    logic signed [16:0] w_xe, w_ye;
    logic            w_in;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_entry;
        end else if (i_dis) begin
            r_entry.flags  <= r_entry.flags | i_dis_mask;
            r_entry.reason <= i_dis_reason;
        end
        r_query <= i_query;
        r_valid <= i_valid;
    end

    assign w_xe = 17'(r_entry.x) + $signed({2'b0, r_entry.w});
    assign w_ye = 17'(r_entry.y) + $signed({2'b0, r_entry.h});
    assign w_in = (r_query.px >= r_entry.x) && (17'(r_query.px) < w_xe) &&
                  (r_query.py >= r_entry.y) && (17'(r_query.py) < w_ye);

    assign o_match = r_valid && (r_query.hit ?
        ((r_entry.flags & r_query.skip) == 8'd0 && r_entry.id != 32'd0 && w_in) :
        (r_entry.id == r_query.id));
    assign o_valid = r_valid;
    assign o_query = r_query;
    assign o_entry = r_entry;
endmodule
`default_nettype wire

// ----- design/widget_hit_table.sv -----
`default_nettype none
// channel   direction  handshake        payload
// input     in         i_valid/o_stall  wht_pkg::t_in
// result    out        o_valid/i_stall  wht_pkg::t_out
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// reset, push and disable-last go from idle straight to the output state; hit and find
// first scan the cell chain, the query walking it one cell per cycle
// synchronous active-low reset clears the counts and restores the mask defaults;
// entries are not cleared
// a result waits in the output register while i_stall is high; o_stall is high
// from acceptance until the result has been taken
module widget_hit_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output      logic          o_stall,
    input  wire wht_pkg::t_in  i_data,
    output      logic          o_valid,
    input  wire logic          i_stall,
    output      wht_pkg::t_out o_data,
    input  wire logic          i_cfg_valid,
    output      logic          o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [7:0]    i_cfg_data
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    logic [7:0] r_hmask, r_dmask;
    logic [CW-1:0] r_fill;
    logic [15:0] r_drops;
    logic [CW-1:0] r_cnt;      // scan cycles elapsed
    logic r_is_hit, r_found;
    logic [IW-1:0] r_fidx;
    wht_pkg::t_entry r_fent;
    wht_pkg::t_out r_out;

    logic w_acc;
    wht_pkg::t_cmd w_cmd;
    wht_pkg::t_entry w_new;
    wht_pkg::t_query w_q0;
    logic [MAX_ENTRIES:0] w_v;
    wht_pkg::t_query w_q [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] w_m;
    wht_pkg::t_entry w_e [MAX_ENTRIES];

    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && !o_stall;
    assign w_cmd = wht_pkg::t_cmd'(i_data.cmd);

    assign w_new = '{id: i_data.widget_id, x: i_data.rect_x, y: i_data.rect_y,
                     w: i_data.rect_w, h: i_data.rect_h, value: i_data.entry_value,
                     flags: i_data.entry_flags, reason: 5'd0};
    assign w_q0 = '{hit: (w_cmd == wht_pkg::CMD_HIT), id: i_data.widget_id,
                    px: i_data.point_x, py: i_data.point_y, skip: r_hmask | r_dmask};

    assign w_v[0] = w_acc && (w_cmd == wht_pkg::CMD_HIT || w_cmd == wht_pkg::CMD_FIND);
    assign w_q[0] = w_q0;

    // query moves through cells 0..N-1, one per cycle
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        wht_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_acc && w_cmd == wht_pkg::CMD_PUSH && r_fill == CW'(g)),
            .i_load_entry(w_new),
            .i_dis       (w_acc && w_cmd == wht_pkg::CMD_DISABLE && r_fill == CW'(g + 1)),
            .i_dis_mask  (r_dmask),
            .i_dis_reason(i_data.reject_reason),
            .i_valid     (w_v[g]),
            .i_query     (w_q[g]),
            .o_valid     (w_v[g+1]),
            .o_query     (w_q[g+1]),
            .o_match     (w_m[g]),
            .o_entry     (w_e[g])
        );
    end

    // cell g reports on scan cycle g; only cells below the fill count count
    logic w_cell_ok;
    logic [IW-1:0] w_ci;
    assign w_ci = r_cnt[IW-1:0];
    assign w_cell_ok = (r_state == S_SCAN) && (r_cnt < r_fill) && w_m[w_ci];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hmask <= wht_pkg::HEADER_MASK_RESET;
            r_dmask <= wht_pkg::DISABLED_MASK_RESET;
            r_fill  <= '0;
            r_drops <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == wht_pkg::CFG_HEADER_MASK) r_hmask <= i_cfg_data;
                else r_dmask <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_out <= '0;
                        r_is_hit <= (w_cmd == wht_pkg::CMD_HIT);
                        r_found <= 1'b0;
                        r_cnt <= '0;
                        r_state <= S_OUT;
                        case (w_cmd)
                            wht_pkg::CMD_RESET: begin
                                r_fill <= '0;
                                r_drops <= '0;
                                r_out.entry_count <= '0;
                                r_out.drop_count <= '0;
                            end
                            wht_pkg::CMD_PUSH: begin
                                if (r_fill == CW'(MAX_ENTRIES)) begin
                                    if (r_drops != 16'hFFFF) r_drops <= r_drops + 16'd1;
                                    r_out.drop_count <= (r_drops != 16'hFFFF) ?
                                        r_drops + 16'd1 : r_drops;
                                    r_out.entry_count <= 7'(r_fill);
                                end else begin
                                    r_fill <= r_fill + CW'(1);
                                    r_out.ok <= 1'b1;
                                    r_out.entry_count <= 7'(r_fill + CW'(1));
                                    r_out.drop_count <= r_drops;
                                end
                            end
                            wht_pkg::CMD_DISABLE: begin
                                r_out.ok <= (r_fill != '0);
                                r_out.entry_count <= 7'(r_fill);
                                r_out.drop_count <= r_drops;
                            end
                            wht_pkg::CMD_HIT, wht_pkg::CMD_FIND: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_out.entry_count <= 7'(r_fill);
                                r_out.drop_count <= r_drops;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    // hit keeps the newest match, find keeps the oldest
                    if (w_cell_ok && (r_is_hit || !r_found)) begin
                        r_found <= 1'b1;
                        r_fidx <= w_ci;
                        r_fent <= w_e[w_ci];
                    end
                    if (r_cnt == CW'(MAX_ENTRIES - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_cnt != '0) begin
                        // first cycle after a scan: build the result
                        r_cnt <= '0;
                        r_out.ok <= r_found;
                        r_out.found_id <= r_found ? r_fent.id : '0;
                        r_out.found_index <= r_found ? 6'(r_fidx) : '0;
                        r_out.found_value <= r_found ? r_fent.value : '0;
                        r_out.found_flags <= r_found ? r_fent.flags : '0;
                        r_out.found_reason <= r_found ? r_fent.reason : '0;
                        r_out.entry_count <= 7'(r_fill);
                        r_out.drop_count <= r_drops;
                    end else if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = (r_state == S_OUT) && (r_cnt == '0);
    assign o_data = r_out;
endmodule
`default_nettype wire
